/* sv/tga_rle_pkg.sv */
// tga_rle_pkg: shared types and constants of the run-length pixel decoder
// no dependencies; imported by the decode core and the top level
`timescale 1ns / 1ps
`default_nettype none

package tga_rle_pkg;

  // configuration port
  localparam int unsigned CFG_IDX_BITS  = 1;
  localparam int unsigned CFG_DATA_BITS = 32;

  localparam logic [CFG_IDX_BITS-1:0] CFG_BYTES_PER_PIXEL = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PIXEL_COUNT     = 1'd1;

  // reset values of the registers
  localparam logic [2:0]  BPP_RESET   = 3'd3;
  localparam logic [31:0] COUNT_RESET = 32'd1;

  // register contents handed to the decode core
  typedef struct packed {
    logic [2:0]  bytes_per_pixel;
    logic [31:0] pixel_count;
  } cfg_t;

  // status flags of one result
  typedef struct packed {
    logic image_done;
    logic overrun_error;
  } res_flags_t;

endpackage

`default_nettype wire

/* sv/tga_rle_byte_if.sv */
// tga_rle_byte_if: valid/ready channel carrying one encoded stream byte
// depends on nothing; used by the top level input port
`timescale 1ns / 1ps
`default_nettype none

interface tga_rle_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

/* sv/tga_rle_res_if.sv */
// tga_rle_res_if: valid/ready channel carrying one decoded pixel result
// depends on nothing; used by the top level output port
`timescale 1ns / 1ps
`default_nettype none

interface tga_rle_res_if #(
  parameter int unsigned PIXEL_INDEX_BITS = 32
);
  logic                        valid;
  logic                        ready;
  logic [31:0]                 pixel_value;
  logic [7:0]                  repeat_count;
  logic [PIXEL_INDEX_BITS-1:0] first_pixel_index;
  logic                        image_done;
  logic                        overrun_error;

  modport source (
    output valid, output pixel_value, output repeat_count,
    output first_pixel_index, output image_done, output overrun_error,
    input ready
  );
  modport sink (
    input valid, input pixel_value, input repeat_count,
    input first_pixel_index, input image_done, input overrun_error,
    output ready
  );
endinterface

`default_nettype wire

/* sv/tga_rle_core.sv */
// tga_rle_core: packet and pixel state of the decoder, one byte per transfer
// depends on tga_rle_pkg
`timescale 1ns / 1ps
`default_nettype none

module tga_rle_core import tga_rle_pkg::*; #(
  parameter int unsigned PIXEL_INDEX_BITS = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        accept_i,
  input  wire logic [7:0]                  in_byte_i,
  input  wire cfg_t                        cfg_i,
  output logic                             res_valid_o,
  output logic [31:0]                      pixel_value_o,
  output logic [7:0]                       repeat_count_o,
  output logic [PIXEL_INDEX_BITS-1:0]      first_index_o,
  output res_flags_t                       flags_o
);

  localparam logic [32:0] CountCap = (33'd1 << PIXEL_INDEX_BITS) - 33'd1;

  // decoding state
  logic                        active_q, active_d;
  logic                        is_run_q, is_run_d;
  logic [7:0]                  ppl_q, ppl_d;
  logic [1:0]                  bip_q, bip_d;
  logic [31:0]                 asm_q, asm_d;
  logic [PIXEL_INDEX_BITS-1:0] done_q, done_d;
  logic [9:0]                  discard_q, discard_d;

  // effective register values
  logic [2:0]                  bpp_eff;
  logic [32:0]                 count_ext;
  logic [32:0]                 count_sat;
  logic [PIXEL_INDEX_BITS-1:0] total;
  logic [PIXEL_INDEX_BITS-1:0] remaining;

  always_comb begin
    if (cfg_i.bytes_per_pixel == 3'd0) begin
      bpp_eff = 3'd1;
    end else if (cfg_i.bytes_per_pixel > 3'd4) begin
      bpp_eff = 3'd4;
    end else begin
      bpp_eff = cfg_i.bytes_per_pixel;
    end
  end

  assign count_ext = {1'b0, cfg_i.pixel_count};

  always_comb begin
    if (cfg_i.pixel_count == 32'd0) begin
      count_sat = 33'd1;
    end else if (count_ext > CountCap) begin
      count_sat = CountCap;
    end else begin
      count_sat = count_ext;
    end
  end

  assign total     = count_sat[PIXEL_INDEX_BITS-1:0];
  assign remaining = (total > done_q) ? (total - done_q) : PIXEL_INDEX_BITS'(1);

  // pixel assembly and packet bookkeeping
  logic [31:0]                 asm_new;
  logic [2:0]                  bip_inc;
  logic [7:0]                  count_raw;
  logic [7:0]                  ppl_m1;
  logic [10:0]                 discard_prod;
  logic                        over;

  assign asm_new      = asm_q | (32'(in_byte_i) << {bip_q, 3'b000});
  assign bip_inc      = {1'b0, bip_q} + 3'd1;
  assign count_raw    = is_run_q ? ppl_q : 8'd1;
  assign ppl_m1       = ppl_q - 8'd1;
  assign discard_prod = 11'(ppl_m1) * 11'(bpp_eff);
  assign over         = PIXEL_INDEX_BITS'(ppl_q) > remaining;

  // next state and result
  always_comb begin
    active_d       = active_q;
    is_run_d       = is_run_q;
    ppl_d          = ppl_q;
    bip_d          = bip_q;
    asm_d          = asm_q;
    done_d         = done_q;
    discard_d      = discard_q;
    res_valid_o    = 1'b0;
    pixel_value_o  = asm_new;
    repeat_count_o = count_raw;
    first_index_o  = done_q;
    flags_o        = '0;
    if (accept_i) begin
      if (discard_q != 10'd0) begin
        discard_d = discard_q - 10'd1;
      end else if (!active_q) begin
        // packet header: both kinds declare low seven bits plus one pixels
        active_d = 1'b1;
        bip_d    = 2'd0;
        asm_d    = '0;
        is_run_d = in_byte_i[7];
        ppl_d    = {1'b0, in_byte_i[6:0]} + 8'd1;
      end else if (bip_inc < bpp_eff) begin
        asm_d = asm_new;
        bip_d = bip_inc[1:0];
      end else begin
        res_valid_o = 1'b1;
        asm_d       = '0;
        bip_d       = 2'd0;
        if (over) begin
          // packet reaches past the image end: clip and drop the rest
          flags_o.image_done    = 1'b1;
          flags_o.overrun_error = 1'b1;
          if (PIXEL_INDEX_BITS'(count_raw) > remaining) begin
            repeat_count_o = remaining[7:0];
          end
          discard_d = is_run_q ? 10'd0 : discard_prod[9:0];
          active_d  = 1'b0;
          ppl_d     = 8'd0;
          done_d    = '0;
        end else begin
          ppl_d = ppl_q - count_raw;
          if (ppl_q == count_raw) begin
            active_d = 1'b0;
          end
          if (PIXEL_INDEX_BITS'(count_raw) >= remaining) begin
            flags_o.image_done = 1'b1;
            done_d             = '0;
            active_d           = 1'b0;
          end else begin
            done_d = done_q + PIXEL_INDEX_BITS'(count_raw);
          end
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      is_run_q  <= 1'b0;
      ppl_q     <= 8'd0;
      bip_q     <= 2'd0;
      asm_q     <= '0;
      done_q    <= '0;
      discard_q <= 10'd0;
    end else begin
      active_q  <= active_d;
      is_run_q  <= is_run_d;
      ppl_q     <= ppl_d;
      bip_q     <= bip_d;
      asm_q     <= asm_d;
      done_q    <= done_d;
      discard_q <= discard_d;
    end
  end

endmodule

`default_nettype wire

/* sv/tga_rle_decoder_unit.sv */
// tga_rle_decoder_unit: run-length pixel decoder, one encoded byte per cycle while ready
// a result is registered in the output register, or in the skid entry while output stalls
// the decode core updates all of its state on each byte it accepts
// a two-entry result buffer keeps input transfers going while one result waits
// reset (asynchronous, active low) clears the decoding state and the buffer
// and restores bytes_per_pixel = 3 and pixel_count = 1
`timescale 1ns / 1ps
`default_nettype none

module tga_rle_decoder_unit import tga_rle_pkg::*; #(
  parameter int unsigned PIXEL_INDEX_BITS = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  tga_rle_byte_if.sink                  byte_i,
  tga_rle_res_if.source                 result_o,
  input  wire logic                     cfg_we_i,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata_i
);

  typedef struct packed {
    logic [31:0]                 pixel_value;
    logic [7:0]                  repeat_count;
    logic [PIXEL_INDEX_BITS-1:0] first_index;
    res_flags_t                  flags;
  } entry_t;

  // configuration registers
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bytes_per_pixel <= BPP_RESET;
      cfg_q.pixel_count     <= COUNT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BYTES_PER_PIXEL: cfg_q.bytes_per_pixel <= cfg_wdata_i[2:0];
        CFG_PIXEL_COUNT:     cfg_q.pixel_count     <= cfg_wdata_i[31:0];
        default: ;
      endcase
    end
  end

  // input transfer
  logic accept;
  logic skid_valid_q;

  assign byte_i.ready = !skid_valid_q;
  assign accept       = byte_i.valid && byte_i.ready;

  // decode core
  logic       res_valid;
  entry_t     res;

  tga_rle_core #(
    .PIXEL_INDEX_BITS (PIXEL_INDEX_BITS)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .in_byte_i      (byte_i.in_byte),
    .cfg_i          (cfg_q),
    .res_valid_o    (res_valid),
    .pixel_value_o  (res.pixel_value),
    .repeat_count_o (res.repeat_count),
    .first_index_o  (res.first_index),
    .flags_o        (res.flags)
  );

  // two-entry result buffer: output register plus skid entry
  logic   out_valid_q;
  entry_t out_q, skid_q;
  logic   pop;

  assign pop = out_valid_q && result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || pop) begin
      out_valid_q  <= skid_valid_q || res_valid;
      skid_valid_q <= 1'b0;
    end else if (res_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || pop) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (res_valid) begin
      skid_q <= res;
    end
  end

  // output transfer
  assign result_o.valid             = out_valid_q;
  assign result_o.pixel_value       = out_q.pixel_value;
  assign result_o.repeat_count      = out_q.repeat_count;
  assign result_o.first_pixel_index = out_q.first_index;
  assign result_o.image_done        = out_q.flags.image_done;
  assign result_o.overrun_error     = out_q.flags.overrun_error;

`ifndef SYNTHESIS
  // the skid entry is only ever filled behind a waiting output
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry holds a result with the output register empty");

  // an overrun always closes the image
  a_overrun_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.flags.overrun_error) |-> out_q.flags.image_done)
    else $error("overrun result without image_done");

  // every result fills at least one pixel
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.repeat_count != 8'd0))
    else $error("result with zero repeat count");

  // a result arriving at a stalled output fills the skid entry and blocks new input
  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !result_o.ready && res_valid) |=> (skid_valid_q && !byte_i.ready))
    else $error("result buffer overflow");
`endif

endmodule

`default_nettype wire
